// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define NKT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion lbl failed");

// Condition must never be true outside reset.
`define NKT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition lbl seen");

`endif

// ===== rtl/core/nkt_pkg.sv =====
`timescale 1ns / 1ps
package nkt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ASSIGN = 2'd0,
      OP_UPDATE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_DONE  = 3'd0,
      ST_FOUND = 3'd1,
      ST_TIE   = 3'd2,
      ST_MISS  = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      RD_MID    = 3'd0,
      RD_POS    = 3'd1,
      RD_POS_DN = 3'd2,
      RD_POS_UP = 3'd3,
      RD_SHIFT  = 3'd4
   } rd_sel_type;

   typedef struct packed {
      logic       load_item;
      rd_sel_type rd_sel;
      logic       srch_step;
      logic       cap_p;
      logic       cap_l;
      logic       cap_u;
      logic       dist_ld;
      logic       act;
      logic       sh_init;
      logic       sh_write;
      logic       ins;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic srch_done;
      logic shift_done;
      logic need_shift;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/core/nearest_key_table.sv =====
`timescale 1ns / 1ps
// Sorted key/value table with nearest-key lookup. Each request transfer carries an
// opcode: assign stores value under key (inserting the key in order if new, or
// answering table full when no slot is free), update-nearest overwrites the value of
// the single nearest key within csr tolerance, query-nearest returns that value, nop
// only answers done. Exactly one response transfer per request. Steps per request,
// with n entries held: take the request, then a binary search over the key memory,
// each probe a read and a compare (one read port, read data registered), at most
// ceil(log2(n+1)) probes, then fetch the neighbors, form the distances and decide,
// then hand off the result, held there for as long as the previous response still
// waits in the output register. An insert of a new key then moves each entry above
// the insertion point up by one, a read then a write on the single memory port,
// before writing the new key. Requests are taken one at a time; the next request is
// accepted while the previous response still sits in the output register. The
// tolerance register may be written only while the block is idle.
module nearest_key_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_found_value,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);

   // command and status bundles between sequencer and datapath
   nkt_pkg::cmd_type  cmd;
   nkt_pkg::stat_type stat;

   nkt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nkt_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_value       (req_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

endmodule

// ===== rtl/core/nkt_ctrl.sv =====
`timescale 1ns / 1ps
module nkt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  nkt_pkg::stat_type  stat,
   output nkt_pkg::cmd_type   cmd
);

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_SRD  = 13'b0000000000010,
      S_SCMP = 13'b0000000000100,
      S_F0   = 13'b0000000001000,
      S_F1   = 13'b0000000010000,
      S_F2   = 13'b0000000100000,
      S_F3   = 13'b0000001000000,
      S_DIST = 13'b0000010000000,
      S_ACT  = 13'b0000100000000,
      S_SHR  = 13'b0001000000000,
      S_SHW  = 13'b0010000000000,
      S_INS  = 13'b0100000000000,
      S_FIN  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = nkt_pkg::cmd_type'('0);
      cmd.rd_sel = nkt_pkg::RD_MID;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_SRD;
            end
         end
         S_SRD: begin
            if (stat.srch_done) begin
               state_in = S_F0;
            end else begin
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            cmd.srch_step = 1'b1;
            state_in      = S_SRD;
         end
         S_F0: begin
            cmd.rd_sel = nkt_pkg::RD_POS;
            state_in   = S_F1;
         end
         S_F1: begin
            cmd.cap_p  = 1'b1;
            cmd.rd_sel = nkt_pkg::RD_POS_DN;
            state_in   = S_F2;
         end
         S_F2: begin
            cmd.cap_l  = 1'b1;
            cmd.rd_sel = nkt_pkg::RD_POS_UP;
            state_in   = S_F3;
         end
         S_F3: begin
            cmd.cap_u = 1'b1;
            state_in  = S_DIST;
         end
         S_DIST: begin
            cmd.dist_ld = 1'b1;
            state_in    = S_ACT;
         end
         S_ACT: begin
            cmd.act = 1'b1;
            if (stat.need_shift) begin
               cmd.sh_init = 1'b1;
               state_in    = S_SHR;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SHR: begin
            cmd.rd_sel = nkt_pkg::RD_SHIFT;
            if (stat.shift_done) begin
               state_in = S_INS;
            end else begin
               state_in = S_SHW;
            end
         end
         S_SHW: begin
            cmd.sh_write = 1'b1;
            state_in     = S_SHR;
         end
         S_INS: begin
            cmd.ins  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/nkt_dpath.sv =====
`timescale 1ns / 1ps
module nkt_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  nkt_pkg::cmd_type          cmd,
   output nkt_pkg::stat_type         stat,
   input  logic [1:0]                req_opcode,
   input  logic signed [31:0]        req_key,
   input  logic signed [31:0]        req_value,
   input  logic                      csr_wr_en,
   input  logic [31:0]               csr_wr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_status,
   output logic signed [31:0]        rsp_found_value
);

   localparam int AW = nkt_pkg::AW;
   localparam int CW = nkt_pkg::CW;

   logic signed [31:0] key_mem [nkt_pkg::TABLE_DEPTH];
   logic signed [31:0] val_mem [nkt_pkg::TABLE_DEPTH];

   logic [31:0]        tol_ff;
   logic [CW-1:0]      count_ff;
   nkt_pkg::opcode_type op_ff;
   logic signed [31:0] key_ff, val_ff;
   logic [CW-1:0]      lo_ff, hi_ff, sh_ff;
   logic signed [31:0] rd_key_ff, rd_val_ff;
   logic signed [31:0] kp_ff, vp_ff, kl_ff, vl_ff, ku_ff, vu_ff;
   logic               exact_ff, has_low_ff, has_up_ff;
   logic [31:0]        low_d_ff, up_d_ff;
   logic [CW-1:0]      low_i_ff, up_i_ff;
   logic signed [31:0] low_v_ff, up_v_ff;
   nkt_pkg::status_type res_st_ff;
   logic signed [31:0] res_v_ff;
   logic               rsp_valid_ff;
   nkt_pkg::status_type rsp_st_ff;
   logic signed [31:0] rsp_v_ff;

   logic [CW:0]        mid_sum;
   logic [CW-1:0]      mid;
   logic [CW-1:0]      pos_dn, pos_up, sh_dn;
   logic [AW-1:0]      rd_addr;
   logic               p_ok, exact, has_low, has_up;
   logic [CW-1:0]      up_i;
   logic signed [31:0] low_k, up_k;
   logic               lsel, usel;
   nkt_pkg::status_type near_st;
   logic               near_up;
   logic [CW-1:0]      near_i;
   logic signed [31:0] near_v;
   logic               full;
   logic               wk_en, wv_en;
   logic [AW-1:0]      wa;
   logic signed [31:0] wkd, wvd;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];
   assign pos_dn  = lo_ff - CW'(1);
   assign pos_up  = lo_ff + CW'(1);
   assign sh_dn   = sh_ff - CW'(1);
   assign full    = (count_ff == CW'(nkt_pkg::TABLE_DEPTH));

   always_comb begin
      case (cmd.rd_sel)
         nkt_pkg::RD_POS:    rd_addr = lo_ff[AW-1:0];
         nkt_pkg::RD_POS_DN: rd_addr = pos_dn[AW-1:0];
         nkt_pkg::RD_POS_UP: rd_addr = pos_up[AW-1:0];
         nkt_pkg::RD_SHIFT:  rd_addr = sh_dn[AW-1:0];
         default:            rd_addr = mid[AW-1:0];
      endcase
   end

   // neighbor selection, from the captured entries around the insertion point
   always_comb begin
      p_ok    = (lo_ff < count_ff);
      exact   = p_ok && (kp_ff == key_ff);
      has_low = exact || (lo_ff != '0);
      up_i    = exact ? pos_up : lo_ff;
      has_up  = (up_i < count_ff);
      low_k   = exact ? kp_ff : kl_ff;
      up_k    = exact ? ku_ff : kp_ff;
   end

   // nearest decision from the registered distances
   always_comb begin
      lsel    = has_low_ff && (!has_up_ff || (low_d_ff < up_d_ff));
      usel    = has_up_ff && (!has_low_ff || (up_d_ff < low_d_ff));
      near_st = nkt_pkg::ST_MISS;
      near_up = 1'b0;
      if (lsel) begin
         if (low_d_ff <= tol_ff) near_st = nkt_pkg::ST_FOUND;
      end else if (usel) begin
         near_up = 1'b1;
         if (up_d_ff <= tol_ff) near_st = nkt_pkg::ST_FOUND;
      end else if (has_low_ff && has_up_ff && (low_d_ff <= tol_ff)) begin
         near_st = nkt_pkg::ST_TIE;
      end
      near_i = near_up ? up_i_ff : low_i_ff;
      near_v = near_up ? up_v_ff : low_v_ff;
   end

   always_comb begin
      wk_en = 1'b0;
      wv_en = 1'b0;
      wa    = lo_ff[AW-1:0];
      wkd   = key_ff;
      wvd   = val_ff;
      if (cmd.sh_write) begin
         wk_en = 1'b1;
         wv_en = 1'b1;
         wa    = sh_ff[AW-1:0];
         wkd   = rd_key_ff;
         wvd   = rd_val_ff;
      end else if (cmd.ins) begin
         wk_en = 1'b1;
         wv_en = 1'b1;
      end else if (cmd.act) begin
         if (op_ff == nkt_pkg::OP_ASSIGN && exact_ff) begin
            wv_en = 1'b1;
         end else if (op_ff == nkt_pkg::OP_UPDATE && near_st == nkt_pkg::ST_FOUND) begin
            wv_en = 1'b1;
            wa    = near_i[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
      if (wk_en) key_mem[wa] <= wkd;
      if (wv_en) val_mem[wa] <= wvd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) tol_ff <= csr_wr_data;
         if (cmd.ins) count_ff <= count_ff + CW'(1);
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= nkt_pkg::opcode_type'(req_opcode);
         key_ff <= req_key;
         val_ff <= req_value;
         lo_ff  <= '0;
         hi_ff  <= count_ff;
      end
      if (cmd.srch_step) begin
         if (rd_key_ff < key_ff) begin
            lo_ff <= mid + CW'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.cap_p) begin
         kp_ff <= rd_key_ff;
         vp_ff <= rd_val_ff;
      end
      if (cmd.cap_l) begin
         kl_ff <= rd_key_ff;
         vl_ff <= rd_val_ff;
      end
      if (cmd.cap_u) begin
         ku_ff <= rd_key_ff;
         vu_ff <= rd_val_ff;
      end
      if (cmd.dist_ld) begin
         exact_ff   <= exact;
         has_low_ff <= has_low;
         has_up_ff  <= has_up;
         // true distance is within 0..2^32-1, so the wrapped 32-bit difference is exact
         low_d_ff   <= key_ff - low_k;
         up_d_ff    <= up_k - key_ff;
         low_i_ff   <= exact ? lo_ff : pos_dn;
         up_i_ff    <= up_i;
         low_v_ff   <= exact ? vp_ff : vl_ff;
         up_v_ff    <= exact ? vu_ff : vp_ff;
      end
      if (cmd.act) begin
         res_v_ff  <= '0;
         res_st_ff <= nkt_pkg::ST_DONE;
         case (op_ff)
            nkt_pkg::OP_ASSIGN: begin
               if (!exact_ff && full) res_st_ff <= nkt_pkg::ST_FULL;
            end
            nkt_pkg::OP_UPDATE: begin
               if (near_st != nkt_pkg::ST_FOUND) res_st_ff <= near_st;
            end
            nkt_pkg::OP_QUERY: begin
               res_st_ff <= near_st;
               if (near_st == nkt_pkg::ST_FOUND) res_v_ff <= near_v;
            end
            default: begin
               res_st_ff <= nkt_pkg::ST_DONE;
            end
         endcase
      end
      if (cmd.sh_init) sh_ff <= count_ff;
      if (cmd.sh_write) sh_ff <= sh_dn;
      if (cmd.rsp_load) begin
         rsp_st_ff <= res_st_ff;
         rsp_v_ff  <= res_v_ff;
      end
   end

   assign stat.srch_done  = !(lo_ff < hi_ff);
   assign stat.shift_done = !(sh_ff > lo_ff);
   assign stat.need_shift = (op_ff == nkt_pkg::OP_ASSIGN) && !exact_ff && !full;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_found_value = rsp_v_ff;

endmodule

// ===== rtl/core/nkt_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nkt_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_found_value
);

   `NKT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `NKT_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_found_value))
   `NKT_NEVER(a_value_only_found, clock, reset, rsp_valid && (rsp_status != nkt_pkg::ST_FOUND) && (rsp_found_value != '0))
   `NKT_NEVER(a_status_legal, clock, reset, rsp_valid && (rsp_status > nkt_pkg::ST_FULL))

endmodule

bind nearest_key_table nkt_chk u_nkt_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_found_value (rsp_found_value)
);

// ===== tb/tb_nearest_key_table.sv =====
`timescale 1ns / 1ps
module tb_nearest_key_table;

   typedef struct {
      nkt_pkg::status_type status;
      logic signed [31:0]  value;
   } answer_type;

   // Shadow copy of the sorted table; predicts the answer to each request transfer.
   class key_table_shadow;
      longint     keys[nkt_pkg::TABLE_DEPTH];
      longint     vals[nkt_pkg::TABLE_DEPTH];
      int         count;
      longint     tol;
      answer_type pending[$];
      int         errors;

      function new();
         count = 0;
         tol = 0;
         errors = 0;
      endfunction

      function int first_not_below(longint k);
         int i;
         for (i = 0; i < count; i++)
            if (keys[i] >= k) return i;
         return count;
      endfunction

      function nkt_pkg::status_type locate(longint k, output int idx);
         int     pos, lo_i, up_i;
         bit     has_lo, has_up;
         longint lo_d, up_d;
         pos = first_not_below(k);
         idx = 0;
         lo_i = 0;
         lo_d = 0;
         up_d = 0;
         if (pos < count && keys[pos] == k) begin
            has_lo = 1;
            lo_i = pos;
            up_i = pos + 1;
         end else begin
            has_lo = pos > 0;
            if (has_lo) lo_i = pos - 1;
            up_i = pos;
         end
         has_up = up_i < count;
         if (has_lo) lo_d = k - keys[lo_i];
         if (has_up) up_d = keys[up_i] - k;
         // a missing neighbor is infinitely far
         if (has_lo && (!has_up || lo_d < up_d)) begin
            if (lo_d <= tol) begin
               idx = lo_i;
               return nkt_pkg::ST_FOUND;
            end
            return nkt_pkg::ST_MISS;
         end
         if (has_up && (!has_lo || up_d < lo_d)) begin
            if (up_d <= tol) begin
               idx = up_i;
               return nkt_pkg::ST_FOUND;
            end
            return nkt_pkg::ST_MISS;
         end
         if (has_lo && has_up && lo_d <= tol) return nkt_pkg::ST_TIE;
         return nkt_pkg::ST_MISS;
      endfunction

      function void note_request(nkt_pkg::opcode_type op, logic signed [31:0] key,
                                 logic signed [31:0] value);
         answer_type          a;
         int                  pos, idx, i;
         longint              k;
         nkt_pkg::status_type r;
         k = longint'(key);
         a.status = nkt_pkg::ST_DONE;
         a.value = 0;
         case (op)
            nkt_pkg::OP_ASSIGN: begin
               pos = first_not_below(k);
               if (pos < count && keys[pos] == k) vals[pos] = value;
               else if (count >= nkt_pkg::TABLE_DEPTH) a.status = nkt_pkg::ST_FULL;
               else begin
                  for (i = count; i > pos; i--) begin
                     keys[i] = keys[i-1];
                     vals[i] = vals[i-1];
                  end
                  keys[pos] = k;
                  vals[pos] = value;
                  count++;
               end
            end
            nkt_pkg::OP_UPDATE: begin
               r = locate(k, idx);
               if (r == nkt_pkg::ST_FOUND) vals[idx] = value;
               else a.status = r;
            end
            nkt_pkg::OP_QUERY: begin
               a.status = locate(k, idx);
               if (a.status == nkt_pkg::ST_FOUND) a.value = vals[idx][31:0];
            end
            default: ;
         endcase
         pending.push_back(a);
      endfunction

      function void check_response(logic [2:0] status, logic signed [31:0] value);
         answer_type a;
         if (pending.size() == 0) begin
            $error("response transfer with nothing expected: status %0d", status);
            errors++;
            return;
         end
         a = pending.pop_front();
         if (status !== a.status) begin
            $error("status: expected %0d, got %0d", a.status, status);
            errors++;
         end
         if (value !== a.value) begin
            $error("found_value: expected %0d, got %0d", a.value, value);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_opcode = 0;
   logic signed [31:0] req_key = 0;
   logic signed [31:0] req_value = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_found_value;
   logic               csr_wr_en = 0;
   logic [31:0]        csr_wr_data = 0;

   key_table_shadow shadow = new();

   // idle percentages of the two sides, changed per phase
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // key pool keeps the random table small so inserts stay cheap
   logic signed [31:0] key_pool[40];

   nearest_key_table dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_key(req_key),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // receiver: stall decision made at every falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // check each response transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         shadow.check_response(rsp_status, rsp_found_value);
   end

   // one request transfer; called at a falling edge, returns at a falling edge
   task automatic send(nkt_pkg::opcode_type op, logic signed [31:0] key,
                       logic signed [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_opcode = op;
      req_key = key;
      req_value = value;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      shadow.note_request(op, key, value);
      @(negedge clock);
   endtask

   // sender holds off until every expected response has arrived
   task automatic drain();
      req_valid = 0;
      while (shadow.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_tolerance(logic [31:0] t);
      drain();
      csr_wr_en = 1;
      csr_wr_data = t;
      @(negedge clock);
      csr_wr_en = 0;
      shadow.tol = longint'(t);
   endtask

   function automatic logic signed [31:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 80)
         return key_pool[$urandom_range(39)] + $signed($urandom_range(16)) - 8;
      if (sel < 90)
         return key_pool[$urandom_range(39)];
      return $urandom();  // far away; mostly a miss
   endfunction

   task automatic random_items(int n);
      int                  i, sel;
      nkt_pkg::opcode_type op;
      for (i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 25) op = nkt_pkg::OP_ASSIGN;
         else if (sel < 55) op = nkt_pkg::OP_UPDATE;
         else if (sel < 95) op = nkt_pkg::OP_QUERY;
         else op = nkt_pkg::OP_NOP;
         // fresh random keys only on lookups so the table does not grow much
         if (op == nkt_pkg::OP_ASSIGN) send(op, key_pool[$urandom_range(39)], $urandom());
         else send(op, pick_key(), $urandom());
      end
   endtask

   task automatic set_random_tolerance();
      case ($urandom_range(4))
         0: write_tolerance(0);
         1: write_tolerance($urandom_range(12));
         2: write_tolerance($urandom_range(1000));
         3: write_tolerance($urandom());
         default: write_tolerance(32'hFFFF_FFFF);
      endcase
   endtask

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int i, ph;
      logic signed [31:0] base;
      for (i = 0; i < 40; i++) begin
         // clustered keys give near ties; some spread over the whole range
         if (i < 20) key_pool[i] = 1000 + 4 * i;
         else key_pool[i] = $urandom();
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty table, extremes, ties, unused opcode
      write_tolerance(0);
      send(nkt_pkg::OP_QUERY, 0, 0);
      send(nkt_pkg::OP_UPDATE, 5, 7);
      send(nkt_pkg::OP_ASSIGN, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send(nkt_pkg::OP_ASSIGN, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send(nkt_pkg::OP_QUERY, 32'sh8000_0000, 0);
      send(nkt_pkg::OP_QUERY, 32'sh7FFF_FFFF, 0);
      send(nkt_pkg::OP_QUERY, 0, 0);
      send(nkt_pkg::OP_ASSIGN, 100, 11);
      send(nkt_pkg::OP_ASSIGN, 110, 22);
      send(nkt_pkg::OP_ASSIGN, 100, -1);      // existing key overwrite
      send(nkt_pkg::OP_NOP, 100, 55);
      write_tolerance(5);
      send(nkt_pkg::OP_QUERY, 105, 0);        // equal distance tie
      send(nkt_pkg::OP_UPDATE, 105, 9);
      send(nkt_pkg::OP_QUERY, 104, 0);
      send(nkt_pkg::OP_UPDATE, 107, 33);
      send(nkt_pkg::OP_QUERY, 109, 0);
      send(nkt_pkg::OP_QUERY, 50, 0);
      write_tolerance(32'hFFFF_FFFF);
      send(nkt_pkg::OP_QUERY, 0, 0);
      send(nkt_pkg::OP_QUERY, 32'sh8000_0001, 0);
      send(nkt_pkg::OP_UPDATE, 32'sh7FFF_FFF0, 32'sh1234_5678);
      send(nkt_pkg::OP_QUERY, 32'sh7FFF_FFFE, 0);

      // random phases, each idle pattern visited twice
      for (ph = 0; ph < 8; ph++) begin
         set_random_tolerance();
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         random_items(40);
      end

      // fill the table with ascending keys, then hit the full case
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_tolerance(3);
      base = 32'sh4000_0000;
      while (shadow.count < nkt_pkg::TABLE_DEPTH) begin
         send(nkt_pkg::OP_ASSIGN, base, $urandom());
         base = base + 2;
      end
      send(nkt_pkg::OP_ASSIGN, base + 1, 1);
      send(nkt_pkg::OP_ASSIGN, 32'sh4000_0001, 2);
      send(nkt_pkg::OP_ASSIGN, 32'sh4000_0002, 3);  // existing key still accepted
      send_idle_pct = 16;
      recv_stall_pct = 16;
      for (i = 0; i < 60; i++)
         send(nkt_pkg::opcode_type'($urandom_range(3)),
              32'sh4000_0000 + $signed($urandom_range(2 * nkt_pkg::TABLE_DEPTH + 10)),
              $urandom());

      drain();
      repeat (50) @(negedge clock);
      if (shadow.errors == 0 && shadow.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
